// ===== src/hcp_pkg.sv =====
// Shared types, constants and mod 26 helpers for the 2x2 Hill cipher core.
package hcp_pkg;

    localparam int LETTER_W = 5;
    localparam int MOD_W    = 12;

    localparam logic [LETTER_W-1:0] LETTER_MOD = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    // Reciprocal of 26 scaled by 2^16, exact for every dividend below 4096.
    localparam logic [MOD_W-1:0] RECIP_26 = 12'd2521;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW0_COL0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW0_COL1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW1_COL0 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW1_COL1 = 3'd3;

    typedef struct packed {
        logic                kind;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } t_item;

    typedef struct packed {
        logic [LETTER_W-1:0] k00;
        logic [LETTER_W-1:0] k01;
        logic [LETTER_W-1:0] k10;
        logic [LETTER_W-1:0] k11;
    } t_key;

    typedef struct packed {
        logic                found;
        logic [LETTER_W-1:0] value;
    } t_inv;

    // Residue mod 26 of a value below 4096, by reciprocal multiplication.
    function automatic logic [LETTER_W-1:0] mod26(input logic [MOD_W-1:0] x);
        logic [2*MOD_W-1:0] p;
        logic [7:0]         q;
        logic [MOD_W-1:0]   r;
        p = {{MOD_W{1'b0}}, x} * {{MOD_W{1'b0}}, RECIP_26};
        q = p[23:16];
        r = x - MOD_W'({4'd0, q} * MOD_W'(LETTER_MOD));
        return r[LETTER_W-1:0];
    endfunction

    // Additive inverse mod 26 of a value below 4096.
    function automatic logic [LETTER_W-1:0] neg26(input logic [MOD_W-1:0] x);
        logic [LETTER_W-1:0] r;
        r = mod26(x);
        return (r == '0) ? '0 : LETTER_MOD - r;
    endfunction

    // Multiplicative inverse mod 26 of a residue, if one exists.
    function automatic t_inv inv26(input logic [LETTER_W-1:0] d);
        t_inv res;
        res.found = 1'b1;
        case (d)
            5'd1:    res.value = 5'd1;
            5'd3:    res.value = 5'd9;
            5'd5:    res.value = 5'd21;
            5'd7:    res.value = 5'd15;
            5'd9:    res.value = 5'd3;
            5'd11:   res.value = 5'd19;
            5'd15:   res.value = 5'd7;
            5'd17:   res.value = 5'd23;
            5'd19:   res.value = 5'd11;
            5'd21:   res.value = 5'd5;
            5'd23:   res.value = 5'd17;
            5'd25:   res.value = 5'd25;
            default: begin
                res.found = 1'b0;
                res.value = '0;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== src/hcp_front.sv =====
// Front stage: takes letter pairs, applies padding and registers the request.
module hcp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [hcp_pkg::LETTER_W-1:0]  i_first,
    input  logic [hcp_pkg::LETTER_W-1:0]  i_second,
    input  logic                          i_pad,
    output logic                          o_valid,
    input  logic                          i_ready,
    output hcp_pkg::t_item                o_item
);

    logic           r_valid;
    hcp_pkg::t_item r_item;
    hcp_pkg::t_item n_item;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_item.kind   = i_kind;
        n_item.first  = i_first;
        n_item.second = i_pad ? hcp_pkg::PAD_LETTER : i_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/hcp_queue.sv =====
// Small request queue between the front stage and the arithmetic pipeline.
module hcp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hcp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output hcp_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hcp_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FULL_CNT) |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !pop)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue fill count beyond depth");

endmodule

// ===== src/hcp_back.sv =====
// Arithmetic pipeline: inverse determinant, working matrix, then the product.
module hcp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hcp_pkg::t_item                i_item,
    input  hcp_pkg::t_key                 i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hcp_pkg::LETTER_W-1:0]  o_first,
    output logic [hcp_pkg::LETTER_W-1:0]  o_second,
    output logic                          o_invalid
);

    localparam int W  = hcp_pkg::LETTER_W;
    localparam int MW = hcp_pkg::MOD_W;

    // Stage 1: determinant and its inverse.
    logic           r1_valid;
    hcp_pkg::t_item r1_item;
    hcp_pkg::t_inv  r1_inv;
    // Stage 2: working matrix.
    logic           r2_valid;
    hcp_pkg::t_item r2_item;
    logic           r2_invalid;
    logic [W-1:0]   r2_m00, r2_m01, r2_m10, r2_m11;
    // Stage 3: result register.
    logic           r3_valid;
    logic [W-1:0]   r3_first, r3_second;
    logic           r3_invalid;

    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r3_valid || i_ready;
    assign rdy2    = !r2_valid || rdy3;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    // Stage 1 arithmetic.
    logic [W-1:0]  d_pos, d_neg, n_det;
    logic [W:0]    det_sum;
    hcp_pkg::t_inv n_inv;

    always_comb begin
        d_pos   = hcp_pkg::mod26(MW'(i_key.k00 * i_key.k11));
        d_neg   = hcp_pkg::mod26(MW'(i_key.k01 * i_key.k10));
        det_sum = {1'b0, d_pos} + {1'b0, hcp_pkg::LETTER_MOD} - {1'b0, d_neg};
        n_det   = (det_sum >= {1'b0, hcp_pkg::LETTER_MOD})
                  ? W'(det_sum - {1'b0, hcp_pkg::LETTER_MOD}) : det_sum[W-1:0];
        n_inv   = hcp_pkg::inv26(n_det);
    end

    // Stage 2 arithmetic.
    logic [W-1:0] n_m00, n_m01, n_m10, n_m11;
    logic         n_invalid2;

    always_comb begin
        if (r1_item.kind == hcp_pkg::KIND_ENCRYPT) begin
            n_m00      = i_key.k00;
            n_m01      = i_key.k01;
            n_m10      = i_key.k10;
            n_m11      = i_key.k11;
            n_invalid2 = 1'b0;
        end else begin
            n_m00      = hcp_pkg::mod26(MW'(i_key.k11 * r1_inv.value));
            n_m01      = hcp_pkg::neg26(MW'(i_key.k01 * r1_inv.value));
            n_m10      = hcp_pkg::neg26(MW'(i_key.k10 * r1_inv.value));
            n_m11      = hcp_pkg::mod26(MW'(i_key.k00 * r1_inv.value));
            n_invalid2 = !r1_inv.found;
        end
    end

    // Stage 3 arithmetic.
    logic [W-1:0] n_first, n_second;

    always_comb begin
        if (r2_invalid) begin
            n_first  = '0;
            n_second = '0;
        end else begin
            n_first  = hcp_pkg::mod26(MW'(r2_m00 * r2_item.first)
                                      + MW'(r2_m01 * r2_item.second));
            n_second = hcp_pkg::mod26(MW'(r2_m10 * r2_item.first)
                                      + MW'(r2_m11 * r2_item.second));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_valid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_item <= i_item;
            r1_inv  <= n_inv;
        end
        if (rdy2 && r1_valid) begin
            r2_item    <= r1_item;
            r2_invalid <= n_invalid2;
            r2_m00     <= n_m00;
            r2_m01     <= n_m01;
            r2_m10     <= n_m10;
            r2_m11     <= n_m11;
        end
        if (rdy3 && r2_valid) begin
            r3_first   <= n_first;
            r3_second  <= n_second;
            r3_invalid <= r2_invalid;
        end
    end

    assign o_valid   = r3_valid;
    assign o_first   = r3_first;
    assign o_second  = r3_second;
    assign o_invalid = r3_invalid;

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> (r3_first < hcp_pkg::LETTER_MOD) && (r3_second < hcp_pkg::LETTER_MOD))
        else $error("result letter out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_invalid) |-> (r3_first == '0) && (r3_second == '0))
        else $error("invalid key result carries non-zero letters");

    a_encrypt_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && (r2_item.kind == hcp_pkg::KIND_ENCRYPT)) |-> !r2_invalid)
        else $error("encrypt request flagged with invalid key");

endmodule

// ===== src/hill_cipher_pair_mod26_core.sv =====
// Top level of the 2x2 Hill cipher core: key registers, front, queue and pipeline.
//
// Channel   Direction  Width  Contents
// s_axis    in         16+2   letter pair, pad flag and encrypt/decrypt kind
// m_axis    out        16+1   result letter pair and key-invalid flag
// cfg       in         3+5    key matrix entry writes, index 0 to 3
//
// One request is accepted per cycle and one result leaves per cycle while
// m_axis_tready stays high. Between its capture in the front register and its
// appearance on m_axis, a request passes through the queue and then each of
// the three arithmetic pipeline stages.
// Reset is synchronous and active low; it empties every stage and loads the
// identity key. A stall on m_axis fills the pipeline, the queue and then the
// front register before s_axis_tready drops.
module hill_cipher_pair_mod26_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] letter_first, [9:5] letter_second, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [0] kind, [1] pad_second
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] out_first, [9:5] out_second, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [0] key_invalid
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hcp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hcp_pkg::LETTER_W-1:0]    i_cfg_data
);

    // Key matrix registers. Writes to an index beyond the four entries are
    // accepted and dropped. The key must only be rewritten while the core is idle,
    // so the pipeline may read it at any stage; the core does not enforce this.
    hcp_pkg::t_key r_key;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k00 <= 5'd1;
            r_key.k01 <= 5'd0;
            r_key.k10 <= 5'd0;
            r_key.k11 <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hcp_pkg::REG_KEY_ROW0_COL0: r_key.k00 <= i_cfg_data;
                hcp_pkg::REG_KEY_ROW0_COL1: r_key.k01 <= i_cfg_data;
                hcp_pkg::REG_KEY_ROW1_COL0: r_key.k10 <= i_cfg_data;
                hcp_pkg::REG_KEY_ROW1_COL1: r_key.k11 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front register: padding is applied here, before the request is queued.
    logic           front_valid;
    logic           front_ready;
    hcp_pkg::t_item front_item;

    hcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_kind   (s_axis_tuser[0]),
        .i_first  (s_axis_tdata[4:0]),
        .i_second (s_axis_tdata[9:5]),
        .i_pad    (s_axis_tuser[1]),
        .o_valid  (front_valid),
        .i_ready  (front_ready),
        .o_item   (front_item)
    );

    // The queue lets the front keep accepting while the pipeline is stalled.
    logic           queue_valid;
    logic           queue_ready;
    hcp_pkg::t_item queue_item;

    hcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    // Arithmetic pipeline; its last stage is the output register.
    logic [hcp_pkg::LETTER_W-1:0] res_first;
    logic [hcp_pkg::LETTER_W-1:0] res_second;

    hcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (queue_valid),
        .o_ready   (queue_ready),
        .i_item    (queue_item),
        .i_key     (r_key),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_first   (res_first),
        .o_second  (res_second),
        .o_invalid (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, res_second, res_first};

endmodule
